/* sv/bjcp_pkg.sv */
// shared types and constants of the band-join chunk probe
// no dependencies; imported by bjcp_front, bjcp_back and band_join_chunk_probe

package bjcp_pkg;

  // chunk store geometry
  localparam int unsigned CHUNK_SIZE = 32;
  localparam int unsigned CNT_W      = $clog2(CHUNK_SIZE + 1);
  localparam int unsigned ADDR_W     = (CHUNK_SIZE > 1) ? $clog2(CHUNK_SIZE) : 1;

  // command queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // field widths
  localparam int unsigned IDX_W  = 32;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned BAND_W = 31;
  localparam int unsigned DIFF_W = KEY_W + 2;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_BAND   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_BAND = CFG_IDX_W'(1);

  localparam logic [BAND_W-1:0] INT_BAND_RST   = BAND_W'(10);
  localparam logic [BAND_W-1:0] FIXED_BAND_RST = BAND_W'(655360);

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_PROBE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_FINISH
  } back_state_e;

  typedef struct packed {
    logic [1:0]              action;
    logic [IDX_W-1:0]        tuple_index;
    logic signed [KEY_W-1:0] int_key;
    logic signed [KEY_W-1:0] fixed_key;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] r_index;
    logic [IDX_W-1:0] s_index;
    logic             match_valid;
    logic             last;
  } out_item_t;

  // classified command as it waits in the queue
  typedef struct packed {
    action_e                 action;
    logic [IDX_W-1:0]        tuple_index;
    logic signed [KEY_W-1:0] int_key;
    logic signed [KEY_W-1:0] fixed_key;
  } cmd_t;

  // one stored R tuple
  typedef struct packed {
    logic [IDX_W-1:0]        tuple_index;
    logic signed [KEY_W-1:0] int_key;
    logic signed [KEY_W-1:0] fixed_key;
  } entry_t;

  typedef struct packed {
    logic [BAND_W-1:0] int_band;
    logic [BAND_W-1:0] fixed_band;
  } band_cfg_t;

endpackage

/* sv/bjcp_front.sv */
// front end: accepts input items, decodes the action and queues commands
// depends on bjcp_pkg

module bjcp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bjcp_pkg::in_item_t in_item_i,
  output logic               q_valid_o,
  output bjcp_pkg::cmd_t     q_cmd_o,
  input  logic               q_pop_i
);
  import bjcp_pkg::*;

  cmd_t              fifo_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              accept;
  logic              keep;
  logic              push;
  cmd_t              cmd;

  assign in_stall_o = (cnt_q == QCNT_W'(QDEPTH));
  assign accept     = in_valid_i && !in_stall_o;

  // classify; the unused code is dropped here
  always_comb begin
    cmd.tuple_index = in_item_i.tuple_index;
    cmd.int_key     = in_item_i.int_key;
    cmd.fixed_key   = in_item_i.fixed_key;
    unique case (in_item_i.action)
      ACT_CLEAR: begin cmd.action = ACT_CLEAR; keep = 1'b1; end
      ACT_LOAD:  begin cmd.action = ACT_LOAD;  keep = 1'b1; end
      ACT_PROBE: begin cmd.action = ACT_PROBE; keep = 1'b1; end
      default:   begin cmd.action = ACT_CLEAR; keep = 1'b0; end
    endcase
  end

  assign push      = accept && keep;
  assign q_valid_o = (cnt_q != '0);
  assign q_cmd_o   = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = q_pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(push) - QCNT_W'(q_pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("queue count overflow");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> q_valid_o)
    else $error("pop from empty queue");

  a_drop_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !keep && !q_pop_i) |=> $stable(cnt_q))
    else $error("unused action code entered the queue");

endmodule

/* sv/bjcp_back.sv */
// back end: chunk store, probe walk with one comparator, result register
// depends on bjcp_pkg

module bjcp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bjcp_pkg::band_cfg_t band_i,
  input  logic                q_valid_i,
  input  bjcp_pkg::cmd_t      q_cmd_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bjcp_pkg::out_item_t out_item_o
);
  import bjcp_pkg::*;

  back_state_e state_q, state_d;

  entry_t                  mem [CHUNK_SIZE];
  entry_t                  rd_q;
  logic                    rd_vld_q, rd_vld_d;
  logic                    rd_en;
  logic                    wr_en;
  logic [CNT_W-1:0]        fill_q, fill_d;
  logic [CNT_W-1:0]        ptr_q, ptr_d;
  logic [IDX_W-1:0]        s_idx_q, s_idx_d;
  logic signed [KEY_W-1:0] s_ikey_q, s_ikey_d;
  logic signed [KEY_W-1:0] s_fkey_q, s_fkey_d;
  logic                    pend_vld_q, pend_vld_d;
  logic [IDX_W-1:0]        pend_r_q, pend_r_d;
  out_item_t               out_q, out_d;
  logic                    out_vld_q, out_vld_d;
  logic                    out_load;
  logic                    out_free;
  logic                    issue;
  logic                    hit;

  logic signed [DIFF_W-1:0] di, df;
  logic signed [DIFF_W-1:0] ib_pos, fb_pos;

  assign out_free = !out_vld_q || !out_stall_i;
  assign issue    = (ptr_q < fill_q);
  assign q_pop_o  = (state_q == ST_IDLE) && q_valid_i;
  assign wr_en    = q_pop_o && (q_cmd_i.action == ACT_LOAD)
                    && (fill_q < CNT_W'(CHUNK_SIZE));

  // differences kept wide so they never wrap
  always_comb begin
    di     = DIFF_W'(s_ikey_q) - DIFF_W'(rd_q.int_key);
    df     = DIFF_W'(s_fkey_q) - DIFF_W'(rd_q.fixed_key);
    ib_pos = signed'(DIFF_W'(band_i.int_band));
    fb_pos = signed'(DIFF_W'(band_i.fixed_band));
    hit    = (di > -ib_pos) && (di < ib_pos) && (df > -fb_pos) && (df < fb_pos);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i && q_cmd_i.action == ACT_PROBE) state_d = ST_PROBE;
      end
      ST_PROBE: begin
        if (!issue && !rd_vld_q) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    fill_d     = fill_q;
    ptr_d      = ptr_q;
    s_idx_d    = s_idx_q;
    s_ikey_d   = s_ikey_q;
    s_fkey_d   = s_fkey_q;
    pend_vld_d = pend_vld_q;
    pend_r_d   = pend_r_q;
    rd_vld_d   = rd_vld_q;
    rd_en      = 1'b0;
    out_load   = 1'b0;
    out_d      = out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_pop_o) begin
          unique case (q_cmd_i.action)
            ACT_CLEAR: fill_d = '0;
            ACT_LOAD: begin
              if (wr_en) fill_d = fill_q + 1'b1;
            end
            ACT_PROBE: begin
              ptr_d      = '0;
              s_idx_d    = q_cmd_i.tuple_index;
              s_ikey_d   = q_cmd_i.int_key;
              s_fkey_d   = q_cmd_i.fixed_key;
              pend_vld_d = 1'b0;
              rd_vld_d   = 1'b0;
            end
            default: fill_d = fill_q;
          endcase
        end
      end
      ST_PROBE: begin
        if (out_free) begin
          rd_en    = issue;
          rd_vld_d = issue;
          if (issue) ptr_d = ptr_q + 1'b1;
          // hold one match back so the final one can carry last
          if (rd_vld_q && hit) begin
            if (pend_vld_q) begin
              out_load = 1'b1;
              out_d    = '{r_index: pend_r_q, s_index: s_idx_q,
                           match_valid: 1'b1, last: 1'b0};
            end
            pend_vld_d = 1'b1;
            pend_r_d   = rd_q.tuple_index;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_load   = 1'b1;
          pend_vld_d = 1'b0;
          if (pend_vld_q) begin
            out_d = '{r_index: pend_r_q, s_index: s_idx_q,
                      match_valid: 1'b1, last: 1'b1};
          end else begin
            out_d = '{r_index: '0, s_index: s_idx_q,
                      match_valid: 1'b0, last: 1'b1};
          end
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_vld_d = 1'b1;
    end else begin
      out_vld_d = out_vld_q && out_stall_i;
    end
  end

  // chunk store, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[fill_q[ADDR_W-1:0]] <= '{tuple_index: q_cmd_i.tuple_index,
                                   int_key: q_cmd_i.int_key,
                                   fixed_key: q_cmd_i.fixed_key};
    end
    if (rd_en) begin
      rd_q <= mem[ptr_q[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    s_idx_q  <= s_idx_d;
    s_ikey_q <= s_ikey_d;
    s_fkey_q <= s_fkey_d;
    pend_r_q <= pend_r_d;
    out_q    <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fill_q     <= '0;
      rd_vld_q   <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      rd_vld_q   <= rd_vld_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(CHUNK_SIZE))
    else $error("fill count beyond chunk size");

  a_rd_in_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == ST_PROBE))
    else $error("read data pending outside probe walk");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROBE) |-> (ptr_q <= fill_q))
    else $error("probe pointer ran past fill count");

  a_finish_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && out_free) |=> (out_vld_q && out_q.last))
    else $error("probe finished without a last item");

  a_walk_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROBE && out_load) |=> (out_q.match_valid && !out_q.last))
    else $error("item during walk marked last");

endmodule

/* sv/band_join_chunk_probe.sv */
// top level of the band-join chunk probe: band registers, front and back
// depends on bjcp_pkg, bjcp_front and bjcp_back

// The block keeps a chunk of up to 32 R tuples and joins S tuples against
// it. A clear item empties the chunk, a load item appends one R tuple (loads
// into a full chunk are dropped) and a probe item walks the filled entries in
// load order, giving one match item per entry whose integer and Q16.16 key
// differences both lie strictly inside the bands; a probe that finds nothing
// gives a single no-match item, and the final item of every probe has last
// set. While the output is not stalled, the single comparator of a probe
// checks one store entry per cycle, read through the registered read port of
// the chunk memory. A two-item command queue sits between the input and the
// back end, and results leave through a one-item output register, so input
// items keep being taken while a result waits, until the queue is full. Band
// registers are written over the config port, which is always ready; the user
// must write them only while the block is idle, which the block itself does
// not enforce. Indexes other than the two bands are ignored.

module band_join_chunk_probe (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  bjcp_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output bjcp_pkg::out_item_t                 out_item_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bjcp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bjcp_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import bjcp_pkg::*;

  logic [BAND_W-1:0] int_band_q, int_band_d;
  logic [BAND_W-1:0] fixed_band_q, fixed_band_d;
  band_cfg_t         band;
  logic              cfg_wr;

  logic              q_valid;
  logic              q_pop;
  cmd_t              q_cmd;

  // band registers, open half-widths
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    int_band_d   = int_band_q;
    fixed_band_d = fixed_band_q;
    if (cfg_wr) begin
      unique case (cfg_index_i)
        CFG_INT_BAND:   int_band_d   = cfg_data_i[BAND_W-1:0];
        CFG_FIXED_BAND: fixed_band_d = cfg_data_i[BAND_W-1:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_band_q   <= INT_BAND_RST;
      fixed_band_q <= FIXED_BAND_RST;
    end else begin
      int_band_q   <= int_band_d;
      fixed_band_q <= fixed_band_d;
    end
  end

  assign band = '{int_band: int_band_q, fixed_band: fixed_band_q};

  // front: accept and classify, queue commands
  bjcp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_valid_o  (q_valid),
    .q_cmd_o    (q_cmd),
    .q_pop_i    (q_pop)
  );

  // back: chunk store and probe walk
  bjcp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .band_i      (band),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
